@@ design/mbrot_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrot_pkg
// shared constants and types for the escape-time unit and its multiplier
// ----------------------------------------------------------------------------
package mbrot_pkg;

    // defaults for the top-level parameters
    localparam int MAX_ITERATIONS_DEF = 255;
    localparam int FRACTION_BITS_DEF  = 28;

    // fixed field widths
    localparam int POINT_W = 32;
    localparam int COUNT_W = 8;

    // which of the three products of one iteration
    typedef enum logic [1:0] {
        PROD_RR = 2'b00,  // zr * zr
        PROD_II = 2'b01,  // zi * zi
        PROD_RI = 2'b10   // zr * zi
    } prod_sel_t;

    // which half-by-half partial product (first letter: operand a)
    typedef enum logic [1:0] {
        PART_LL = 2'b00,
        PART_LH = 2'b01,
        PART_HL = 2'b10,
        PART_HH = 2'b11
    } part_sel_t;

    typedef struct packed {
        logic      valid;
        prod_sel_t prod;
        part_sel_t part;
    } mul_ctrl_t;

endpackage

@@ design/mbrot_mul_unit.sv @@
// ----------------------------------------------------------------------------
// mbrot_mul_unit
// shared signed multiplier: one half-by-half partial product per cycle,
// registered, then extended and aligned to the full product width
// ----------------------------------------------------------------------------
module mbrot_mul_unit #(
    parameter int WORK_W = 36
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [WORK_W-1:0]   op_a,
    input  logic signed [WORK_W-1:0]   op_b,
    input  mbrot_pkg::mul_ctrl_t       ctrl_in,
    output mbrot_pkg::mul_ctrl_t       ctrl_out,
    output logic signed [2*WORK_W-1:0] term
);

    localparam int LO_W   = (WORK_W + 1) / 2;
    localparam int HI_W   = WORK_W - LO_W;
    localparam int OP_W   = LO_W + 1;
    localparam int PP_W   = 2 * OP_W;
    localparam int PROD_W = 2 * WORK_W;

    logic signed [OP_W-1:0]   a_half;
    logic signed [OP_W-1:0]   b_half;
    logic signed [PP_W-1:0]   pp_reg;
    logic signed [PP_W-1:0]   pp_next;
    logic signed [PROD_W-1:0] pp_ext;
    mbrot_pkg::mul_ctrl_t     ctrl_reg;

    // high halves are signed, low halves unsigned
    always_comb
    begin
        if (ctrl_in.part == mbrot_pkg::PART_HL || ctrl_in.part == mbrot_pkg::PART_HH)
        begin
            a_half = {{(OP_W-HI_W){op_a[WORK_W-1]}}, op_a[WORK_W-1:LO_W]};
        end
        else
        begin
            a_half = {1'b0, op_a[LO_W-1:0]};
        end
        if (ctrl_in.part == mbrot_pkg::PART_LH || ctrl_in.part == mbrot_pkg::PART_HH)
        begin
            b_half = {{(OP_W-HI_W){op_b[WORK_W-1]}}, op_b[WORK_W-1:LO_W]};
        end
        else
        begin
            b_half = {1'b0, op_b[LO_W-1:0]};
        end
        pp_next = a_half * b_half;
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= pp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    // alignment by the weight of the two halves
    always_comb
    begin
        pp_ext = {{(PROD_W-PP_W){pp_reg[PP_W-1]}}, pp_reg};
        unique case (ctrl_reg.part)
            mbrot_pkg::PART_LL: term = pp_ext;
            mbrot_pkg::PART_LH: term = pp_ext <<< LO_W;
            mbrot_pkg::PART_HL: term = pp_ext <<< LO_W;
            mbrot_pkg::PART_HH: term = pp_ext <<< (2 * LO_W);
            default:            term = pp_ext;
        endcase
    end

    assign ctrl_out = ctrl_reg;

endmodule

@@ design/mandelbrot_escape_time_unit.sv @@
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// escape-time count of one complex point, z <- z*z + c from z = 0
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low; the point
// c is given as signed fixed point with FRACTION_BITS fraction bits (Q4.28 by
// default). The unit iterates z <- z*z + c while |z|^2 <= 4 and the count is
// below MAX_ITERATIONS, and reports the count on iteration_count with done
// high for exactly one cycle; the receiver cannot stall, so the result must be
// taken in that cycle. Busy stays high from the accepting edge until the
// result cycle, in which a new request may already be taken. In each iteration
// the three products zr*zr, zi*zi and zr*zi are each built from four
// half-width partial products on one shared multiplier (S_MUL), then S_FLUSH
// drains the multiplier register and S_TEST does the escape compare and the z
// update. The escape test is exact: products are kept at full width.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit #(
    parameter int MAX_ITERATIONS = mbrot_pkg::MAX_ITERATIONS_DEF,
    parameter int FRACTION_BITS  = mbrot_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [mbrot_pkg::POINT_W-1:0]  point_real,
    input  logic signed [mbrot_pkg::POINT_W-1:0]  point_imag,
    output logic                                  done,
    output logic        [mbrot_pkg::COUNT_W-1:0]  iteration_count
);

    // working width: room for |z| up to 4 + |c| in the worst case
    localparam int WORK_W = (FRACTION_BITS + 8 > mbrot_pkg::POINT_W + 1) ?
                            FRACTION_BITS + 8 : mbrot_pkg::POINT_W + 1;
    localparam int PROD_W = 2 * WORK_W;
    localparam int CNT_W  = $clog2(MAX_ITERATIONS + 1);
    localparam int EXT_W  = WORK_W - mbrot_pkg::POINT_W;

    // escape bound 4.0 at the scale of a product
    localparam logic signed [PROD_W-1:0] LIMIT =
        {{(PROD_W-1){1'b0}}, 1'b1} <<< (2 * FRACTION_BITS + 2);
    localparam logic [3:0]       LAST_STEP = 4'd11;
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_ITERATIONS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_TEST  = 4'b1000
    } state_t;

    state_t                          state_reg,  state_next;
    logic [3:0]                      step_reg,   step_next;
    logic [CNT_W-1:0]                count_reg,  count_next;
    logic                            done_reg,   done_next;
    logic [mbrot_pkg::COUNT_W-1:0]   result_reg, result_next;

    logic signed [WORK_W-1:0]        zr_reg,    zr_next;
    logic signed [WORK_W-1:0]        zi_reg,    zi_next;
    logic signed [WORK_W-1:0]        cr_reg,    cr_next;
    logic signed [WORK_W-1:0]        ci_reg,    ci_next;
    logic signed [PROD_W-1:0]        mag_reg,   mag_next;    // zr^2 + zi^2
    logic signed [PROD_W-1:0]        diff_reg,  diff_next;   // zr^2 - zi^2
    logic signed [PROD_W-1:0]        cross_reg, cross_next;  // zr * zi

    mbrot_pkg::mul_ctrl_t            mul_ctrl;
    mbrot_pkg::mul_ctrl_t            acc_ctrl;
    logic signed [WORK_W-1:0]        op_a;
    logic signed [WORK_W-1:0]        op_b;
    logic signed [PROD_W-1:0]        term;

    logic                            escaped;
    logic signed [PROD_W-1:0]        diff_shift;
    logic signed [PROD_W-1:0]        cross_shift;
    logic signed [WORK_W-1:0]        new_real;
    logic signed [WORK_W-1:0]        new_imag;
    logic [CNT_W-1:0]                count_inc;
    logic [CNT_W+mbrot_pkg::COUNT_W-1:0] count_ext;

    // step counter picks the product and the partial product
    always_comb
    begin
        mul_ctrl.valid = (state_reg == S_MUL);
        mul_ctrl.prod  = mbrot_pkg::prod_sel_t'(step_reg[3:2]);
        mul_ctrl.part  = mbrot_pkg::part_sel_t'(step_reg[1:0]);
        unique case (mul_ctrl.prod)
            mbrot_pkg::PROD_RR:
            begin
                op_a = zr_reg;
                op_b = zr_reg;
            end
            mbrot_pkg::PROD_II:
            begin
                op_a = zi_reg;
                op_b = zi_reg;
            end
            mbrot_pkg::PROD_RI:
            begin
                op_a = zr_reg;
                op_b = zi_reg;
            end
            default:
            begin
                op_a = zr_reg;
                op_b = zi_reg;
            end
        endcase
    end

    mbrot_mul_unit #(
        .WORK_W (WORK_W)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_a     (op_a),
        .op_b     (op_b),
        .ctrl_in  (mul_ctrl),
        .ctrl_out (acc_ctrl),
        .term     (term)
    );

    // escape test and next z, floored back to the working scale
    always_comb
    begin
        escaped     = (mag_reg > LIMIT);
        diff_shift  = diff_reg >>> FRACTION_BITS;
        cross_shift = cross_reg >>> (FRACTION_BITS - 1);
        new_real    = diff_shift[WORK_W-1:0] + cr_reg;
        new_imag    = cross_shift[WORK_W-1:0] + ci_reg;
        count_inc   = count_reg + 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        zr_next     = zr_reg;
        zi_next     = zi_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        mag_next    = mag_reg;
        diff_next   = diff_reg;
        cross_next  = cross_reg;
        count_ext   = {{mbrot_pkg::COUNT_W{1'b0}}, count_reg};

        // partial products land in the cycle after they are issued
        if (acc_ctrl.valid)
        begin
            unique case (acc_ctrl.prod)
                mbrot_pkg::PROD_RR:
                begin
                    mag_next  = mag_reg + term;
                    diff_next = diff_reg + term;
                end
                mbrot_pkg::PROD_II:
                begin
                    mag_next  = mag_reg + term;
                    diff_next = diff_reg - term;
                end
                mbrot_pkg::PROD_RI:
                begin
                    cross_next = cross_reg + term;
                end
                default:
                begin
                    cross_next = cross_reg;
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cr_next    = {{EXT_W{point_real[mbrot_pkg::POINT_W-1]}}, point_real};
                    ci_next    = {{EXT_W{point_imag[mbrot_pkg::POINT_W-1]}}, point_imag};
                    zr_next    = '0;
                    zi_next    = '0;
                    mag_next   = '0;
                    diff_next  = '0;
                    cross_next = '0;
                    count_next = '0;
                    step_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = S_FLUSH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (escaped)
                begin
                    // escaped before this step: report the steps so far
                    done_next   = 1'b1;
                    result_next = count_ext[mbrot_pkg::COUNT_W-1:0];
                    state_next  = S_IDLE;
                end
                else
                begin
                    zr_next    = new_real;
                    zi_next    = new_imag;
                    count_next = count_inc;
                    mag_next   = '0;
                    diff_next  = '0;
                    cross_next = '0;
                    if (count_inc == COUNT_MAX)
                    begin
                        // bounded point: stop at the limit, low bits of the count
                        count_ext   = {{mbrot_pkg::COUNT_W{1'b0}}, count_inc};
                        done_next   = 1'b1;
                        result_next = count_ext[mbrot_pkg::COUNT_W-1:0];
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        mag_reg    <= mag_next;
        diff_reg   <= diff_next;
        cross_reg  <= cross_next;
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign iteration_count = result_reg;

endmodule

@@ design/mbrot_checker.sv @@
// ----------------------------------------------------------------------------
// mbrot_checker
// port-level checks on request and result timing of the escape-time unit
// ----------------------------------------------------------------------------
module mbrot_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic [mbrot_pkg::COUNT_W-1:0]        iteration_count
);

    // a taken request makes the unit busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("request taken but unit not busy");

    // the result cycle is never a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("result shown while busy");

    // busy ends exactly with a result, and a result only ends busy
    assert property (@(posedge clk) disable iff (!rst_n)
        done == $fell(busy))
    else $error("result strobe and end of busy disagree");

    // no result in the cycle after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
    else $error("result too early, count %0d", iteration_count);

endmodule

bind mandelbrot_escape_time_unit mbrot_checker u_mbrot_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .iteration_count (iteration_count)
);

@@ test/tb_mandelbrot_escape_time_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_unit
// self-checking bench for the escape-time unit: every request is predicted
// at full precision and the count that comes back on done is compared in order
// ----------------------------------------------------------------------------

// expected escape counts of the requests that are in flight
class escape_count_tracker;

    typedef struct {
        logic [31:0] c_real;
        logic [31:0] c_imag;
        logic [7:0]  count;
    } point_entry_t;

    point_entry_t expected_counts[$];
    int           failures;

    function new();
        failures = 0;
    endfunction

    // exact iteration of z <- z*z + c, flooring back to the fraction width
    function automatic logic [7:0] predict_escape_count(logic signed [31:0] c_real,
                                                        logic signed [31:0] c_imag);
        localparam int FB = mbrot_pkg::FRACTION_BITS_DEF;
        logic signed [127:0] wide_r, wide_i, sq_r, sq_i, cross_prod, radius_sq;
        longint              z_real, z_imag;
        int unsigned         steps;
        bit                  escaped;
        radius_sq = '0;
        radius_sq[2*FB+2] = 1'b1;
        z_real = 0;
        z_imag = 0;
        steps = 0;
        escaped = 1'b0;
        while (!escaped && steps < mbrot_pkg::MAX_ITERATIONS_DEF)
        begin
            wide_r = z_real;
            wide_i = z_imag;
            sq_r = wide_r * wide_r;
            sq_i = wide_i * wide_i;
            if (sq_r + sq_i > radius_sq)
                escaped = 1'b1;
            else
            begin
                cross_prod = wide_r * wide_i;
                z_real = longint'((sq_r - sq_i) >>> FB) + longint'(c_real);
                z_imag = longint'(cross_prod >>> (FB - 1)) + longint'(c_imag);
                steps++;
            end
        end
        return steps[7:0];
    endfunction

    task report_mismatch(string msg);
        failures++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void note_request(logic [31:0] c_real, logic [31:0] c_imag);
        point_entry_t entry;
        entry.c_real = c_real;
        entry.c_imag = c_imag;
        entry.count  = predict_escape_count(c_real, c_imag);
        expected_counts.push_back(entry);
    endfunction

    task check_count(logic [7:0] got);
        point_entry_t entry;
        if (expected_counts.size() == 0)
            report_mismatch($sformatf("count %0d with no request waiting", got));
        else
        begin
            entry = expected_counts.pop_front();
            if (got !== entry.count)
                report_mismatch($sformatf("c=(%h,%h) iteration_count %0d, want %0d",
                                          entry.c_real, entry.c_imag, got, entry.count));
        end
    endtask

    function int pending();
        return expected_counts.size();
    endfunction

    task check_leftovers();
        point_entry_t entry;
        while (expected_counts.size() != 0)
        begin
            entry = expected_counts.pop_front();
            report_mismatch($sformatf("c=(%h,%h) never answered",
                                      entry.c_real, entry.c_imag));
        end
    endtask

endclass

module tb_mandelbrot_escape_time_unit;

    // Q4.28 constants used to place points
    localparam logic [31:0] Q_ONE     = 32'h1000_0000;
    localparam logic [31:0] Q_TWO     = 32'h2000_0000;
    localparam logic [31:0] Q_NEG_TWO = 32'hE000_0000;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;

    localparam int RANDOM_REQUESTS = 1928;
    localparam int QUIET_TAIL      = 250;   // no idling over the last requests
    localparam int SETTLE_CYCLES   = 3600;  // longer than one bounded point

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] point_real;
    logic [31:0] point_imag;
    logic        done;
    logic [7:0]  iteration_count;

    escape_count_tracker tracker = new();

    mandelbrot_escape_time_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .point_real      (point_real),
        .point_imag      (point_imag),
        .done            (done),
        .iteration_count (iteration_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // every done pulse carries the count of the oldest open request
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_count(iteration_count);
    end

    // present one request and hold it until an edge with busy low takes it;
    // start is left high so the next request can follow without a gap
    task send_point(input logic [31:0] c_real, input logic [31:0] c_imag);
        @(negedge clk);
        start      <= 1'b1;
        point_real <= c_real;
        point_imag <= c_imag;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_request(c_real, c_imag);
    endtask

    // drop start, optionally wait for every open request to be answered,
    // then stay quiet for a burst of cycles
    task hold_off(input int burst, input bit drain);
        @(negedge clk);
        start <= 1'b0;
        if (drain)
            while (tracker.pending() != 0)
                @(negedge clk);
        repeat (burst) @(negedge clk);
    endtask

    // random point, spread over a few regions of interest
    task pick_point(output logic [31:0] c_real, output logic [31:0] c_imag);
        int unsigned region;
        int          offset_r, offset_i;
        logic [31:0] special[6];
        special = '{32'h0, Q_MIN, Q_MAX, 32'hFFFF_FFFF, 32'h1, 32'h1 << $urandom_range(31)};
        region = $urandom_range(99);
        if (region < 33)
        begin
            // any bit pattern: almost always gone after the first step
            c_real = $urandom;
            c_imag = $urandom;
        end
        else if (region < 63)
        begin
            // window around the set, real -2.25..0.75, imag -1.5..1.5
            c_real = -32'sd603979776 + $urandom_range(805306368);
            c_imag = -32'sd402653184 + $urandom_range(805306368);
        end
        else if (region < 85)
        begin
            // close to the radius-two circle on one of the axes, where the
            // escape compare is right at its limit
            offset_r = int'($urandom_range(2097152)) - 1048576;
            offset_i = int'($urandom_range(2097152)) - 1048576;
            if ($urandom_range(3) == 0)
                offset_i = 0;
            case ($urandom_range(3))
                0:
                begin
                    c_real = Q_TWO + offset_r;
                    c_imag = offset_i;
                end
                1:
                begin
                    c_real = Q_NEG_TWO + offset_r;
                    c_imag = offset_i;
                end
                2:
                begin
                    c_real = offset_i;
                    c_imag = Q_TWO + offset_r;
                end
                default:
                begin
                    c_real = offset_i;
                    c_imag = Q_NEG_TWO + offset_r;
                end
            endcase
        end
        else
        begin
            // one field at zero, all ones, an extreme or a single set bit, the other free
            if ($urandom_range(1))
            begin
                c_real = special[$urandom_range(5)];
                c_imag = $urandom;
            end
            else
            begin
                c_real = $urandom;
                c_imag = special[$urandom_range(5)];
            end
        end
    endtask

    initial
    begin
        logic [31:0] directed_real[22];
        logic [31:0] directed_imag[22];
        logic [31:0] c_real, c_imag;
        int unsigned roll;
        bit          idle_on;

        rst_n      = 1'b0;
        start      = 1'b0;
        point_real = '0;
        point_imag = '0;

        // origin, corners of the field range, boundary cases on both axes,
        // the cusp at 0.25, flooring of tiny negatives and |c| close to two
        directed_real = '{32'h0, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 32'h0,
                          Q_NEG_TWO, Q_TWO, Q_TWO + 1, Q_NEG_TWO - 1, 32'h0, 32'h0,
                          32'h0400_0000, 32'h0420_0000, 32'hF000_0000, Q_ONE,
                          32'hFFFF_FFFF, 32'h1, 32'hF400_0000, 32'hFFFF_FFFF,
                          32'h16A0_9E66};
        directed_imag = '{32'h0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 32'h0, Q_MIN,
                          32'h0, 32'h0, 32'h0, 32'h0, Q_TWO, Q_ONE,
                          32'h0, 32'h0, 32'h0, 32'h0,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0199_999A, Q_TWO,
                          32'h16A0_9E66};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed requests back to back
        foreach (directed_real[k])
            send_point(directed_real[k], directed_imag[k]);

        // sender waits until the unit has answered everything
        hold_off(0, 1'b1);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            pick_point(c_real, c_imag);
            send_point(c_real, c_imag);

            // idling in alternating stretches, none in the tail
            idle_on = (n < RANDOM_REQUESTS - QUIET_TAIL) && ((n / 150) % 3 != 2);
            if (idle_on)
            begin
                roll = $urandom_range(99);
                if (roll < 25)
                    hold_off($urandom_range(1, 10), 1'b0);
                else if (roll < 35)
                    hold_off($urandom_range(1, 10), 1'b1);
                else if (roll < 40)
                    hold_off(0, 1'b1);
            end
        end

        hold_off(0, 1'b1);
        // catch any stray done pulse after the last answer
        repeat (SETTLE_CYCLES) @(negedge clk);
        tracker.check_leftovers();

        if (tracker.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #700_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
